### hdl/cba_pkg.sv
// contiguous block allocator: shared types, sizes and codes
// used by contiguous_block_allocator_top, cba_checker and tb_top, depends on nothing
`timescale 1ns / 1ps
`default_nettype none
package cba_pkg;

    localparam int MaxSeg = 32;
    localparam int IdxW   = $clog2(MaxSeg);
    localparam int CntW   = IdxW + 1;
    localparam int UnitW  = 17;
    localparam int IdW    = 8;
    localparam logic [UnitW-1:0] AddrCap = 17'd65536;

    localparam logic [1:0] REQ_ALLOC  = 2'd0;
    localparam logic [1:0] REQ_FREE   = 2'd1;
    localparam logic [1:0] REQ_DEFRAG = 2'd2;
    localparam logic [1:0] REQ_NONE   = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OOM      = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_NOFIT    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;

    localparam logic [1:0] CFG_MEM_SIZE = 2'd0;
    localparam logic [1:0] CFG_POLICY   = 2'd1;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [IdW-1:0]   req_id;
        logic [UnitW-1:0] req_size;
    } t_req;

    typedef struct packed {
        logic [2:0]       status;
        logic [UnitW-1:0] seg_start;
        logic [UnitW-1:0] seg_end;
        logic [UnitW-1:0] free_left;
    } t_res;

    typedef struct packed {
        logic [IdW-1:0]   id;
        logic [UnitW-1:0] lo;
        logic [UnitW-1:0] hi;
    } t_seg;

endpackage
`default_nettype wire

### hdl/contiguous_block_allocator_top.sv
// contiguous block allocator: segment table in a one-port-read memory, scan and shift sequencer
// depends on cba_pkg
`timescale 1ns / 1ps
//
// channel   | direction | transfer when                 | payload
// request   | in        | start high and busy low       | i_req (t_req)
// result    | out       | o_done high, one cycle        | o_result (t_res)
// config    | in        | i_cfg_valid and o_cfg_ready   | i_cfg_index, i_cfg_data
//
// one request at a time; n = segments held, m = entries shifted; steps from start to result:
// scan of n segments, decide, shift of m entries, insert, result; allocate runs all of them,
// deallocate all but insert, failures scan, decide and result, defragment scan and result,
// unknown type result only; idle follows each result; scan and shift read one entry per cycle
// synchronous reset empties the table; config writes are taken only when idle
// results cannot be stalled
`default_nettype none
module contiguous_block_allocator_top
    import cba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire t_req             i_req,
    output logic                  o_done,
    output t_res                  o_result,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [UnitW-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_FINAL = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_INS   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    function automatic logic f_cand(input logic [UnitW-1:0] len, input logic [UnitW-1:0] size,
                                    input logic [UnitW-1:0] best, input logic found,
                                    input logic pol);
        return (len >= size) && (!found || (pol && (len < best)));
    endfunction

    t_seg r_mem [0:MaxSeg-1];
    t_seg r_rdata;

    logic [2:0]       r_state;
    t_req             r_req;
    logic [UnitW-1:0] r_limit;
    logic             r_policy;
    logic [CntW-1:0]  r_count;
    logic [UnitW-1:0] r_free;
    logic [IdxW-1:0]  r_ra;
    logic [CntW-1:0]  r_left;
    logic             r_down;
    logic             r_rv;
    logic [IdxW-1:0]  r_pa;
    logic             r_dup;
    logic             r_found;
    logic [CntW-1:0]  r_pick;
    logic [UnitW-1:0] r_best;
    logic [UnitW-1:0] r_best_hs;
    logic [UnitW-1:0] r_prev_hi;
    logic [UnitW-1:0] r_at;
    logic [2:0]       r_status;
    logic [UnitW-1:0] r_s;
    logic [UnitW-1:0] r_e;

    logic             rd_en;
    logic             mem_we;
    logic [IdxW-1:0]  mem_wa;
    t_seg             mem_wd;
    logic [UnitW-1:0] rd_len;
    logic [UnitW-1:0] hole_len;
    logic [UnitW-1:0] last_len;
    logic             cand_last;
    logic [UnitW-1:0] pick_hs;
    logic [CntW-1:0]  pick_sel;
    logic [UnitW-1:0] new_limit;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_done      = (r_state == S_OUT);
    assign o_result    = '{status: r_status, seg_start: r_s, seg_end: r_e, free_left: r_free};

    assign rd_en    = ((r_state == S_SCAN) || (r_state == S_SHIFT)) && (r_left != '0);
    assign rd_len   = (r_rdata.hi >= r_rdata.lo) ? r_rdata.hi - r_rdata.lo : '0;
    assign hole_len = (r_rdata.lo >= r_prev_hi) ? r_rdata.lo - r_prev_hi : '0;
    assign last_len = (r_limit >= r_prev_hi) ? r_limit - r_prev_hi : '0;
    assign cand_last = f_cand(last_len, r_req.req_size, r_best, r_found, r_policy);
    assign pick_hs   = cand_last ? r_prev_hi : r_best_hs;
    assign pick_sel  = cand_last ? r_count : r_pick;
    assign new_limit = (i_cfg_data > AddrCap) ? AddrCap : i_cfg_data;

    always_comb begin
        mem_we = 1'b0;
        mem_wa = r_pa;
        mem_wd = r_rdata;
        case (r_state)
            S_SCAN: begin
                if (r_rv && (r_req.req_type == REQ_DEFRAG)) begin
                    mem_we = 1'b1;
                    mem_wd = '{id: r_rdata.id, lo: r_at, hi: r_at + rd_len};
                end
            end
            S_SHIFT: begin
                if (r_rv) begin
                    mem_we = 1'b1;
                    mem_wa = r_down ? r_pa + 1'b1 : r_pa - 1'b1;
                end
            end
            S_INS: begin
                mem_we = 1'b1;
                mem_wa = r_pick[IdxW-1:0];
                mem_wd = '{id: r_req.req_id, lo: r_s, hi: r_e};
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= AddrCap;
            r_policy <= 1'b0;
            r_count  <= '0;
            r_free   <= AddrCap;
            r_rv     <= 1'b0;
            r_left   <= '0;
        end else begin
            r_rv <= rd_en;
            r_pa <= r_ra;
            if (rd_en) begin
                r_left <= r_left - 1'b1;
                r_ra   <= r_down ? r_ra - 1'b1 : r_ra + 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == CFG_MEM_SIZE) begin
                            r_limit <= new_limit;
                            r_free  <= new_limit;
                            r_count <= '0;
                        end else if (i_cfg_index == CFG_POLICY) begin
                            r_policy <= i_cfg_data[0];
                        end
                    end
                    if (start) begin
                        r_req     <= i_req;
                        r_dup     <= 1'b0;
                        r_found   <= 1'b0;
                        r_pick    <= '0;
                        r_best    <= '0;
                        r_best_hs <= '0;
                        r_prev_hi <= '0;
                        r_at      <= '0;
                        r_status  <= ST_OK;
                        r_s       <= '0;
                        r_e       <= '0;
                        r_ra      <= '0;
                        r_down    <= 1'b0;
                        r_left    <= r_count;
                        r_state   <= (i_req.req_type == REQ_NONE) ? S_OUT : S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rv) begin
                        case (r_req.req_type)
                            REQ_ALLOC: begin
                                if (r_rdata.id == r_req.req_id) begin
                                    r_dup <= 1'b1;
                                end
                                if (f_cand(hole_len, r_req.req_size, r_best, r_found,
                                           r_policy)) begin
                                    r_found   <= 1'b1;
                                    r_pick    <= {1'b0, r_pa};
                                    r_best    <= hole_len;
                                    r_best_hs <= r_prev_hi;
                                end
                                r_prev_hi <= r_rdata.hi;
                            end
                            REQ_FREE: begin
                                if (!r_found && (r_rdata.id == r_req.req_id)) begin
                                    r_found <= 1'b1;
                                    r_pick  <= {1'b0, r_pa};
                                    r_s     <= r_rdata.lo;
                                    r_e     <= r_rdata.hi;
                                end
                            end
                            default: begin
                                r_at <= r_at + rd_len;
                            end
                        endcase
                    end else if (r_left == '0) begin
                        r_state <= (r_req.req_type == REQ_DEFRAG) ? S_OUT : S_FINAL;
                    end
                end
                S_FINAL: begin
                    r_state <= S_OUT;
                    if (r_req.req_type == REQ_ALLOC) begin
                        if (r_req.req_size > r_free) begin
                            r_status <= ST_OOM;
                        end else if (r_dup) begin
                            r_status <= ST_DUP;
                        end else if (r_count >= CntW'(MaxSeg)) begin
                            r_status <= ST_FULL;
                        end else if (!(r_found || cand_last)) begin
                            r_status <= ST_NOFIT;
                        end else begin
                            r_s     <= pick_hs;
                            r_e     <= pick_hs + r_req.req_size;
                            r_free  <= r_free - r_req.req_size;
                            r_count <= r_count + 1'b1;
                            r_pick  <= pick_sel;
                            r_left  <= r_count - pick_sel;
                            r_ra    <= r_count[IdxW-1:0] - 1'b1;
                            r_down  <= 1'b1;
                            r_state <= S_SHIFT;
                        end
                    end else if (!r_found) begin
                        r_status <= ST_NOTFOUND;
                    end else begin
                        r_free  <= r_free + ((r_e >= r_s) ? r_e - r_s : '0);
                        r_count <= r_count - 1'b1;
                        r_left  <= r_count - 1'b1 - r_pick;
                        r_ra    <= r_pick[IdxW-1:0] + 1'b1;
                        r_down  <= 1'b0;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    if (!r_rv && (r_left == '0)) begin
                        r_state <= (r_req.req_type == REQ_ALLOC) ? S_INS : S_OUT;
                    end
                end
                S_INS: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(MaxSeg))
        else $error("segment count above table depth");

    a_free_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_limit)
        else $error("free units above memory size");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !mem_we)
        else $error("table written while idle");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule
`default_nettype wire

### tb/cba_checker.sv
// contiguous block allocator checker: watches request, config and result transfers,
// keeps its own segment table to predict each result and compares field by field
// depends on cba_pkg
`timescale 1ns / 1ps
`default_nettype none
module cba_checker
    import cba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic             busy,
    input  wire t_req             i_req,
    input  wire logic             o_done,
    input  wire t_res             o_result,
    input  wire logic             i_cfg_valid,
    input  wire logic             o_cfg_ready,
    input  wire logic [1:0]       i_cfg_index,
    input  wire logic [UnitW-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);

    t_seg tbl [MaxSeg];
    int   seg_cnt;
    int   free_units;
    int   mem_lim;
    logic pol_best;
    t_res expected_q [$];

    task automatic clear_table();
        seg_cnt    = 0;
        free_units = mem_lim;
    endtask

    task automatic apply_cfg(input logic [1:0] idx, input logic [UnitW-1:0] data);
        if (idx == CFG_MEM_SIZE) begin
            mem_lim = (int'(data) > 65536) ? 65536 : int'(data);
            clear_table();
        end else if (idx == CFG_POLICY) begin
            pol_best = data[0];
        end
    endtask

    function automatic int hole_lo(input int k);
        return (k == 0) ? 0 : int'(tbl[k-1].hi);
    endfunction

    function automatic int hole_hi(input int k);
        return (k >= seg_cnt) ? mem_lim : int'(tbl[k].lo);
    endfunction

    task automatic predict_result(input t_req r, output t_res o);
        int   sz;
        int   s;
        int   e;
        int   k;
        int   pick;
        int   best;
        int   len;
        int   at;
        logic dup;
        logic found;
        logic [2:0] st;
        sz = int'(r.req_size);
        s = 0;
        e = 0;
        st = ST_OK;
        if (r.req_type == REQ_ALLOC) begin
            dup = 1'b0;
            for (k = 0; k < seg_cnt; k++)
                if (tbl[k].id == r.req_id) dup = 1'b1;
            if (sz > free_units) begin
                st = ST_OOM;
            end else if (dup) begin
                st = ST_DUP;
            end else if (seg_cnt >= MaxSeg) begin
                st = ST_FULL;
            end else begin
                found = 1'b0;
                pick = 0;
                best = 0;
                for (k = 0; k <= seg_cnt; k++) begin
                    len = (hole_hi(k) >= hole_lo(k)) ? hole_hi(k) - hole_lo(k) : 0;
                    if (len < sz) continue;
                    if (!found || (pol_best && len < best)) begin
                        found = 1'b1;
                        pick = k;
                        best = len;
                        if (!pol_best) break;
                    end
                end
                if (!found) begin
                    st = ST_NOFIT;
                end else begin
                    s = hole_lo(pick);
                    e = s + sz;
                    for (k = seg_cnt; k > pick; k--) tbl[k] = tbl[k-1];
                    tbl[pick].id = r.req_id;
                    tbl[pick].lo = UnitW'(s);
                    tbl[pick].hi = UnitW'(e);
                    seg_cnt++;
                    free_units -= sz;
                end
            end
        end else if (r.req_type == REQ_FREE) begin
            pick = seg_cnt;
            for (k = 0; k < seg_cnt; k++) begin
                if (tbl[k].id == r.req_id) begin
                    pick = k;
                    break;
                end
            end
            if (pick >= seg_cnt) begin
                st = ST_NOTFOUND;
            end else begin
                s = int'(tbl[pick].lo);
                e = int'(tbl[pick].hi);
                free_units += (e >= s) ? e - s : 0;
                for (k = pick; k + 1 < seg_cnt; k++) tbl[k] = tbl[k+1];
                seg_cnt--;
            end
        end else if (r.req_type == REQ_DEFRAG) begin
            at = 0;
            for (k = 0; k < seg_cnt; k++) begin
                len = (tbl[k].hi >= tbl[k].lo) ? int'(tbl[k].hi) - int'(tbl[k].lo) : 0;
                tbl[k].lo = UnitW'(at);
                tbl[k].hi = UnitW'(at + len);
                at += len;
            end
        end
        o.status    = st;
        o.seg_start = UnitW'(s);
        o.seg_end   = UnitW'(e);
        o.free_left = UnitW'(free_units);
    endtask

    task automatic check_field(input string name, input int exp_v, input int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v,
                     act_v);
            o_errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_res want;
        if (!i_rst_n) begin
            mem_lim  = 65536;
            pol_best = 1'b0;
            clear_table();
            expected_q.delete();
            o_errors   = 0;
            o_pending <= 0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) apply_cfg(i_cfg_index, i_cfg_data);
            if (start && !busy) begin
                predict_result(i_req, want);
                expected_q.push_back(want);
            end
            if (o_done) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: result with none expected, actual %p", $realtime, o_result);
                    o_errors++;
                end else begin
                    want = expected_q.pop_front();
                    check_field("status", int'(want.status), int'(o_result.status));
                    check_field("seg_start", int'(want.seg_start), int'(o_result.seg_start));
                    check_field("seg_end", int'(want.seg_end), int'(o_result.seg_end));
                    check_field("free_left", int'(want.free_left), int'(o_result.free_left));
                end
            end
            o_pending <= expected_q.size();
        end
    end

endmodule
`default_nettype wire

### tb/tb_top.sv
// testbench top for contiguous_block_allocator_top: directed and random requests,
// config phases and sender gaps; checking is done in cba_checker
// depends on cba_pkg, cba_checker and the block
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    import cba_pkg::*;

    localparam int CycleLimit = 600000;
    localparam int SettleCycles = 4 * MaxSeg + 20;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_req             i_req = '0;
    logic             o_done;
    t_res             o_result;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [1:0]       i_cfg_index = CFG_MEM_SIZE;
    logic [UnitW-1:0] i_cfg_data = '0;
    int               errors;
    int               pending;
    int               cycles = 0;
    int               idle_pct = 0;
    int               mem_now = 65536;

    always #5 i_clk = ~i_clk;

    contiguous_block_allocator_top dut (.*);

    cba_checker u_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_req, .o_done, .o_result,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_req(input logic [1:0] kind, input logic [7:0] id,
                            input logic [UnitW-1:0] sz);
        int gap;
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_req <= '{req_type: kind, req_id: id, req_size: sz};
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [UnitW-1:0] data);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_MEM_SIZE) mem_now = (int'(data) > 65536) ? 65536 : int'(data);
    endtask

    task automatic random_item();
        int               pick;
        logic [1:0]       kind;
        logic [7:0]       id;
        logic [UnitW-1:0] sz;
        pick = $urandom_range(99);
        kind = (pick < 50) ? REQ_ALLOC : (pick < 85) ? REQ_FREE :
               (pick < 95) ? REQ_DEFRAG : REQ_NONE;
        id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 47));
        pick = $urandom_range(99);
        if (pick < 10) sz = '0;
        else if (pick < 15) sz = UnitW'($urandom);
        else sz = UnitW'($urandom_range(0, (mem_now / 8 > 0) ? mem_now / 8 : 1));
        send_req(kind, id, sz);
    endtask

    task automatic random_phase(input int pct, input logic [UnitW-1:0] msz,
                                input logic pol, input int n, input logic pauses);
        write_cfg(CFG_MEM_SIZE, msz);
        write_cfg(CFG_POLICY, {16'($urandom), pol});
        idle_pct = pct;
        for (int k = 0; k < n; k++) begin
            random_item();
            if (pauses && k % 40 == 39) drain();
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero size, extremes, every status but ST_FULL and every request type
        send_req(REQ_ALLOC, 8'd0, '0);
        send_req(REQ_ALLOC, 8'd255, 17'd100);
        send_req(REQ_ALLOC, 8'd255, 17'd5);
        send_req(REQ_ALLOC, 8'd1, 17'd65536);
        send_req(REQ_FREE, 8'd7, '0);
        send_req(REQ_FREE, 8'd0, '0);
        send_req(REQ_ALLOC, 8'd2, 17'd65436);
        send_req(REQ_ALLOC, 8'd3, 17'h1FFFF);
        send_req(REQ_FREE, 8'd255, 17'h1FFFF);
        send_req(REQ_DEFRAG, 8'hAA, 17'h15555);
        send_req(REQ_NONE, 8'h55, 17'h0AAAA);
        send_req(REQ_FREE, 8'd2, '0);
        write_cfg(CFG_MEM_SIZE, 17'd10);
        write_cfg(CFG_POLICY, 17'd1);
        send_req(REQ_ALLOC, 8'd1, 17'd2);
        send_req(REQ_ALLOC, 8'd2, 17'd3);
        send_req(REQ_ALLOC, 8'd3, 17'd1);
        send_req(REQ_ALLOC, 8'd4, 17'd4);
        send_req(REQ_FREE, 8'd1, '0);
        send_req(REQ_FREE, 8'd3, '0);
        send_req(REQ_ALLOC, 8'd5, 17'd3);
        send_req(REQ_ALLOC, 8'd6, 17'd1);
        send_req(REQ_DEFRAG, 8'd0, '0);
        send_req(REQ_ALLOC, 8'd7, 17'd2);
        write_cfg(2'd2, 17'h1FFFF);
        write_cfg(2'd3, 17'h1FFFF);

        random_phase(0, 17'd65536, 1'b0, 120, 1'b0);
        random_phase(76, 17'd300, 1'b1, 120, 1'b1);
        random_phase(20, 17'd1, 1'b0, 80, 1'b0);
        random_phase(0, 17'd128, 1'b1, 130, 1'b0);
        random_phase(76, 17'h1FFFF, 1'b1, 120, 1'b0);
        random_phase(20, 17'd200, 1'b0, 130, 1'b0);
        random_phase(0, 17'd65535, 1'b1, 120, 1'b1);
        random_phase(20, 17'd64, 1'b0, 110, 1'b0);

        drain();
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
`default_nettype wire
